// ----- sv/rnp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix number parser package
// Character codes, register indexes, count widths and the digit decode shared
// by the parser, its port checker and its testbench.
// ----------------------------------------------------------------------------
package rnp_pkg;

    // Width of the digit and length counters.
    localparam int COUNT_W = 16;

    // Configuration register indexes.
    localparam logic [0:0] REG_NUMBER_BASE = 1'b0;
    localparam logic [0:0] REG_SKIP_BLANKS = 1'b1;

    // Radix limits and letter digit offset.
    localparam logic [5:0] MIN_RADIX   = 6'd2;
    localparam logic [5:0] MAX_RADIX   = 6'd36;
    localparam logic [7:0] LETTER_BASE = 8'd10;

    // ASCII codes.
    localparam logic [7:0] CASE_FOLD  = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_A_LC  = 8'h61;
    localparam logic [7:0] CHAR_Z_LC  = 8'h7A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    // Decoded digit: hit is set when the character is a digit of the radix.
    typedef struct packed {
        logic       hit;
        logic [5:0] value;
    } digit_t;

    // Clamp the configured base into the supported radix range.
    function automatic logic [5:0] clamp_radix(input logic [5:0] base);
        logic [5:0] radix;
        if (base < MIN_RADIX) begin
            radix = MIN_RADIX;
        end else if (base > MAX_RADIX) begin
            radix = MAX_RADIX;
        end else begin
            radix = base;
        end
        return radix;
    endfunction

    // Map a character to its digit value; letters fold to lower case.
    function automatic digit_t decode_digit(input logic [7:0] c, input logic [5:0] radix);
        digit_t     d;
        logic [7:0] lc;
        logic [7:0] raw;
        logic       is_char;
        lc = c | CASE_FOLD;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            raw     = c - CHAR_ZERO;
            is_char = 1'b1;
        end else if (lc >= CHAR_A_LC && lc <= CHAR_Z_LC) begin
            raw     = lc - CHAR_A_LC + LETTER_BASE;
            is_char = 1'b1;
        end else begin
            raw     = 8'd0;
            is_char = 1'b0;
        end
        d.value = raw[5:0];
        d.hit   = is_char && (raw[5:0] < radix);
        return d;
    endfunction

    // Count up by one, holding at all ones.
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (&v) ? v : v + COUNT_W'(1);
    endfunction

endpackage

// ----- sv/radix_number_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix number parser
// Scans an ASCII character stream and reports one unsigned number per scan.
// ----------------------------------------------------------------------------
// The block takes one character per clock and never stalls for work: each
// character passes an input register and a combinational decode and
// multiply-add against the scan state; the scan that a terminating character
// closes lands in the result register, which drives the result request.
// A character with
// the start flag in tuser opens a new scan (dropping any scan in progress);
// leading spaces and tabs may be skipped when enabled, digits accumulate as
// value = value * radix + digit, and the first non-digit closes the scan and
// produces one result request without being part of the number. The input
// side only holds off when a terminating character finds the result register
// still occupied by an untaken request. The radix register accepts 0..63 and
// is clamped into 2..36. Configuration is meant to change only while no scan
// is active.
module radix_number_parser_top
    import rnp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    localparam int M_TDATA_W = ((VALUE_WIDTH + 2 * COUNT_W + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    // Configuration: index 0 number_base, index 1 skip_leading_blanks.
    input  logic                 cfg_wr_en,
    input  logic [0:0]           cfg_wr_index,
    input  logic [5:0]           cfg_wr_data,

    // Character input.
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] char_in
    input  logic [0:0]           s_axis_tuser,   // [0] start_scan

    // Result output.
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // parsed_value, digit_count,
                                                 // scanned_length, zero pad
    output logic [1:0]           m_axis_tuser    // [0] nothing_scanned,
                                                 // [1] value_wrapped
);

    localparam int PROD_W = VALUE_WIDTH + 6;

    // Scan phase codes.
    localparam logic [1:0] PHASE_IDLE   = 2'd0;
    localparam logic [1:0] PHASE_LEAD   = 2'd1;
    localparam logic [1:0] PHASE_DIGITS = 2'd2;

    // Configuration registers.
    logic [5:0] number_base_reg;
    logic       skip_blanks_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            number_base_reg <= 6'd10;
            skip_blanks_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_NUMBER_BASE: number_base_reg <= cfg_wr_data;
                REG_SKIP_BLANKS: skip_blanks_reg <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_start_reg;
    logic       advance;

    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_char_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
    end

    // Scan state.
    logic [1:0]             phase_reg, phase_next;
    logic [VALUE_WIDTH-1:0] acc_reg, acc_next;
    logic [COUNT_W-1:0]     digits_reg, digits_next;
    logic [COUNT_W-1:0]     chars_reg, chars_next;
    logic                   ovf_reg, ovf_next;

    // Working values after a possible restart.
    logic [1:0]             cur_phase;
    logic [VALUE_WIDTH-1:0] cur_acc;
    logic [COUNT_W-1:0]     cur_digits;
    logic [COUNT_W-1:0]     cur_chars;
    logic                   cur_ovf;
    logic [5:0]             radix;
    digit_t                 dig;
    logic [PROD_W-1:0]      product;
    logic                   is_blank;
    logic                   emit;

    always_comb begin
        if (in_start_reg) begin
            cur_phase  = PHASE_LEAD;
            cur_acc    = '0;
            cur_digits = '0;
            cur_chars  = '0;
            cur_ovf    = 1'b0;
        end else begin
            cur_phase  = phase_reg;
            cur_acc    = acc_reg;
            cur_digits = digits_reg;
            cur_chars  = chars_reg;
            cur_ovf    = ovf_reg;
        end

        radix    = clamp_radix(number_base_reg);
        dig      = decode_digit(in_char_reg, radix);
        product  = PROD_W'(cur_acc) * PROD_W'(radix) + PROD_W'(dig.value);
        is_blank = (in_char_reg == CHAR_SPACE) || (in_char_reg == CHAR_TAB);

        phase_next  = cur_phase;
        acc_next    = cur_acc;
        digits_next = cur_digits;
        chars_next  = cur_chars;
        ovf_next    = cur_ovf;
        emit        = 1'b0;

        if (cur_phase == PHASE_IDLE) begin
            // No scan open: the character is dropped.
        end else if (cur_phase == PHASE_LEAD && skip_blanks_reg && is_blank) begin
            chars_next = sat_inc(cur_chars);
        end else if (dig.hit) begin
            acc_next    = product[VALUE_WIDTH-1:0];
            ovf_next    = cur_ovf || (|product[PROD_W-1:VALUE_WIDTH]);
            digits_next = sat_inc(cur_digits);
            chars_next  = sat_inc(cur_chars);
            phase_next  = PHASE_DIGITS;
        end else begin
            // Terminator: report the scan and close it.
            emit       = 1'b1;
            phase_next = PHASE_IDLE;
        end
    end

    // Output register and stall decision.
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    logic [COUNT_W-1:0]     out_digits_reg;
    logic [COUNT_W-1:0]     out_chars_reg;
    logic                   out_empty_reg;
    logic                   out_wrap_reg;
    logic                   out_free;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign advance  = in_valid_reg && (!emit || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PHASE_IDLE;
        end else if (advance) begin
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            digits_reg <= '0;
            chars_reg  <= '0;
            ovf_reg    <= 1'b0;
        end else if (advance) begin
            acc_reg    <= acc_next;
            digits_reg <= digits_next;
            chars_reg  <= chars_next;
            ovf_reg    <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && emit) begin
            out_value_reg  <= cur_acc;
            out_digits_reg <= cur_digits;
            out_chars_reg  <= cur_chars;
            out_empty_reg  <= (cur_digits == '0);
            out_wrap_reg   <= cur_ovf;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_chars_reg, out_digits_reg, out_value_reg});
    assign m_axis_tuser  = {out_wrap_reg, out_empty_reg};

endmodule

// ----- sv/rnp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix number parser port checker
// Watches the result channel of the parser for consistent requests.
// ----------------------------------------------------------------------------
module rnp_checker
    import rnp_pkg::*;
#(
    parameter int VALUE_WIDTH = 32,
    localparam int M_TDATA_W = ((VALUE_WIDTH + 2 * COUNT_W + 7) / 8) * 8
) (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]           m_axis_tuser
);

    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_W-1:0]     digits;
    logic [COUNT_W-1:0]     length;

    assign value  = m_axis_tdata[VALUE_WIDTH-1:0];
    assign digits = m_axis_tdata[VALUE_WIDTH+COUNT_W-1:VALUE_WIDTH];
    assign length = m_axis_tdata[VALUE_WIDTH+2*COUNT_W-1:VALUE_WIDTH+COUNT_W];

    // A stalled request keeps its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result payload changed while stalled");

    // An empty scan reports zero value, no digits and no wrap; any digit clears the flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser[0] == (digits == '0)) &&
            (!m_axis_tuser[0] || (value == '0 && !m_axis_tuser[1])))
        else $error("nothing_scanned inconsistent with result");

    // Scanned length includes every digit.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> digits <= length)
        else $error("digit count exceeds scanned length");

    // Reset empties the result register.
    assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

bind radix_number_parser_top rnp_checker #(
    .VALUE_WIDTH(VALUE_WIDTH)
) u_rnp_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix number parser testbench
// Streams character requests into the parser and checks every result request
// against a cycle-free model of the scan that the bench keeps alongside. The
// run goes through directed cases, a long output stall, and random traffic
// under several radix and blank settings.
// ----------------------------------------------------------------------------
module tb
    import rnp_pkg::*;
();

    localparam int VALUE_W          = 32;
    localparam int RES_TDATA_W      = ((VALUE_W + 2 * COUNT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT      = 200_000;
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS     = 1750;
    localparam int RANDOM_PHASES    = 10;

    // Printable characters used as terminators; none is a digit or a blank.
    localparam logic [7:0] CHAR_BANG   = 8'h21;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_LBRACE = 8'h7B;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_LEAD,
        SCAN_DIGITS
    } scan_phase_t;

    typedef enum int {
        RX_OPEN,
        RX_RANDOM,
        RX_COMB
    } rx_style_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COUNT_W-1:0] digits;
        logic [COUNT_W-1:0] length;
        logic               none;
        logic               wrapped;
    } parse_result_t;

    // DUT connections.
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [0:0]             cfg_wr_index = '0;
    logic [5:0]             cfg_wr_data = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [7:0]             s_axis_tdata = '0;   // [7:0] char_in
    logic [0:0]             s_axis_tuser = '0;   // [0] start_scan
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [RES_TDATA_W-1:0] m_axis_tdata;        // parsed_value, digit_count,
                                                 // scanned_length, zero pad
    logic [1:0]             m_axis_tuser;        // [0] nothing_scanned,
                                                 // [1] value_wrapped

    // Scan model state and its copy of the registers.
    logic [5:0]         cfg_base = 6'd10;
    logic               cfg_skip = 1'b0;
    scan_phase_t        scan_phase = SCAN_IDLE;
    logic [VALUE_W-1:0] acc_value = '0;
    logic [COUNT_W-1:0] digits_seen = '0;
    logic [COUNT_W-1:0] char_cnt = '0;
    logic               wrap_seen = 1'b0;

    parse_result_t expected_results[$];
    int            mismatch_count = 0;
    int            chars_sent = 0;
    int            burst_left = 1;
    int            cycle_count = 0;
    int            hold_req_seq = 0;

    radix_number_parser_top #(
        .VALUE_WIDTH(VALUE_W)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_index  (cfg_wr_index),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scan model
    // ------------------------------------------------------------------------

    // The base register holds 0..63; values outside 2..36 act as the nearest limit.
    function automatic logic [5:0] radix_in_use();
        if (cfg_base < 6'd2) begin
            return 6'd2;
        end else if (cfg_base > 6'd36) begin
            return 6'd36;
        end
        return cfg_base;
    endfunction

    // Digit value for any radix, or -1 when the character is no digit at all.
    function automatic int char_digit_value(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | CASE_FOLD;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            return int'(c - CHAR_ZERO);
        end else if (folded >= CHAR_A_LC && folded <= CHAR_Z_LC) begin
            return int'(folded - CHAR_A_LC) + int'(LETTER_BASE);
        end
        return -1;
    endfunction

    function automatic bit char_is_digit(input logic [7:0] c, input logic [5:0] radix);
        int dv;
        dv = char_digit_value(c);
        return dv >= 0 && dv < int'(radix);
    endfunction

    function automatic logic [COUNT_W-1:0] count_up(input logic [COUNT_W-1:0] v);
        return (&v) ? v : v + COUNT_W'(1);
    endfunction

    // Advance the scan by one character; returns 1 when it closes a scan.
    function automatic bit parse_char(input logic [7:0] c, input logic start,
                                      output parse_result_t res);
        logic [5:0]  radix;
        logic [63:0] wide;
        radix = radix_in_use();
        res = '0;
        if (start) begin
            scan_phase  = SCAN_LEAD;
            acc_value   = '0;
            digits_seen = '0;
            char_cnt    = '0;
            wrap_seen   = 1'b0;
        end
        if (scan_phase == SCAN_IDLE) begin
            return 1'b0;
        end
        // Leading blanks are consumed only before the first digit.
        if (scan_phase == SCAN_LEAD && cfg_skip && (c == CHAR_SPACE || c == CHAR_TAB)) begin
            char_cnt = count_up(char_cnt);
            return 1'b0;
        end
        if (char_is_digit(c, radix)) begin
            wide = 64'(acc_value) * 64'(radix) + 64'(char_digit_value(c));
            if (wide[63:VALUE_W] != '0) begin
                wrap_seen = 1'b1;
            end
            acc_value   = wide[VALUE_W-1:0];
            digits_seen = count_up(digits_seen);
            char_cnt    = count_up(char_cnt);
            scan_phase  = SCAN_DIGITS;
            return 1'b0;
        end
        // Any other character closes the scan without being consumed.
        res.value   = acc_value;
        res.digits  = digits_seen;
        res.length  = char_cnt;
        res.none    = (digits_seen == '0);
        res.wrapped = wrap_seen;
        scan_phase  = SCAN_IDLE;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------------
    // Character sender: bursts of requests with random gaps between them
    // ------------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic start);
        parse_result_t res;
        int            gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tuser  <= start;
        do @(posedge aclk); while (!s_axis_tready);
        if (parse_char(c, start, res)) begin
            expected_results.push_back(res);
        end
        chars_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            // Mostly short bursts, now and then a long unbroken stretch.
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            gap = $urandom_range(0, 5);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    function automatic logic [7:0] random_digit_char(input logic [5:0] radix);
        int d;
        d = $urandom_range(0, int'(radix) - 1);
        if (d < 10) begin
            return CHAR_ZERO + 8'(d);
        end
        // Letters in either case.
        return ($urandom_range(0, 1) ? CHAR_A_LC : CHAR_A_LC - CASE_FOLD)
               + 8'(d) - LETTER_BASE;
    endfunction

    function automatic logic [7:0] random_blank();
        return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
    endfunction

    // Close any open scan, then wait until the block has nothing left in flight.
    task automatic drain_block();
        send_char(CHAR_BANG, 1'b0);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write both registers; only called while the block is drained.
    task automatic write_config(input logic [5:0] base, input logic skip);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_NUMBER_BASE;
        cfg_wr_data  <= base;
        @(posedge aclk);
        cfg_wr_index <= REG_SKIP_BLANKS;
        cfg_wr_data  <= {5'd0, skip};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_base = base;
        cfg_skip = skip;
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: its own stall pattern plus an optional long hold-off
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive_ready
        static rx_style_t rx_style = RX_OPEN;
        static int        style_left = 0;
        static int        hold_left = 0;
        static int        hold_seen = 0;
        static int        rx_tick = 0;
        rx_tick++;
        if (hold_req_seq != hold_seen) begin
            hold_seen = hold_req_seq;
            hold_left = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style   = rx_style_t'($urandom_range(0, 2));
                style_left = $urandom_range(16, 160);
            end
            style_left--;
            case (rx_style)
                RX_OPEN: begin
                    m_axis_tready <= 1'b1;
                end
                RX_RANDOM: begin
                    m_axis_tready <= ($urandom_range(0, 2) != 0);
                end
                default: begin
                    m_axis_tready <= (rx_tick % 5) < 2;
                end
            endcase
        end
    end

    // Compare each result request with the oldest expectation.
    always @(posedge aclk) begin : check_results
        parse_result_t      want;
        logic [VALUE_W-1:0] got_value;
        logic [COUNT_W-1:0] got_digits;
        logic [COUNT_W-1:0] got_length;
        got_value  = m_axis_tdata[VALUE_W-1:0];
        got_digits = m_axis_tdata[VALUE_W +: COUNT_W];
        got_length = m_axis_tdata[VALUE_W + COUNT_W +: COUNT_W];
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no scan pending: value %0d", got_value);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (got_value !== want.value) begin
                    $error("parsed_value: expected %0d, got %0d", want.value, got_value);
                    mismatch_count++;
                end
                if (got_digits !== want.digits) begin
                    $error("digit_count: expected %0d, got %0d", want.digits, got_digits);
                    mismatch_count++;
                end
                if (got_length !== want.length) begin
                    $error("scanned_length: expected %0d, got %0d", want.length, got_length);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== want.none) begin
                    $error("nothing_scanned: expected %0d, got %0d", want.none,
                           m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (m_axis_tuser[1] !== want.wrapped) begin
                    $error("value_wrapped: expected %0d, got %0d", want.wrapped,
                           m_axis_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timed out after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset settings: decimal, no blank skipping. 2^32 wraps to zero and a
    // blank after the digits ends the scan.
    task automatic test_reset_defaults();
        logic [7:0] text [10];
        text = '{"4", "2", "9", "4", "9", "6", "7", "2", "9", "6"};
        foreach (text[i]) begin
            send_char(text[i], i == 0);
        end
        send_char(CHAR_SPACE, 1'b0);
    endtask

    // A character without the start flag while idle is dropped; a scan that
    // starts on a non-digit reports nothing scanned.
    task automatic test_idle_and_empty();
        send_char("Z", 1'b0);
        send_char(CHAR_BANG, 1'b1);
    endtask

    // Radix 36 with skipping: blanks before digits, letters in both cases,
    // a blank after a digit, a restart mid-scan and a scan of blanks only.
    task automatic test_blanks_letters_restart();
        drain_block();
        write_config(6'd36, 1'b1);
        send_char(CHAR_SPACE, 1'b1);
        send_char(CHAR_TAB, 1'b0);
        send_char("z", 1'b0);
        send_char("Z", 1'b0);
        send_char(CHAR_SPACE, 1'b0);
        send_char("1", 1'b1);
        send_char("2", 1'b1);
        send_char(CHAR_DOT, 1'b0);
        send_char(CHAR_SPACE, 1'b1);
        send_char(CHAR_BANG, 1'b0);
    endtask

    // Base values below 2 and above 36 are clamped.
    task automatic test_radix_clamp();
        drain_block();
        write_config(6'd0, 1'b0);
        send_char("1", 1'b1);
        send_char("2", 1'b0);
        drain_block();
        write_config(6'd63, 1'b0);
        send_char("z", 1'b1);
        send_char(CHAR_LBRACE, 1'b0);
        send_char(8'hFF, 1'b1);
    endtask

    // Hold off the result side for a long stretch while short scans keep
    // coming, so the result register fills and the input side stalls.
    task automatic test_output_backpressure();
        drain_block();
        hold_req_seq <= hold_req_seq + 1;
        repeat (32) begin
            send_char(random_digit_char(radix_in_use()), 1'b1);
            send_char(CHAR_BANG, 1'b0);
        end
    endtask

    // One scan: optional blanks, digits, then a terminator; with skipping off a leading blank closes it.
    task automatic random_scan();
        logic [5:0] radix;
        logic [7:0] term;
        int         n_blank;
        int         n_digit;
        bit         first;
        radix   = radix_in_use();
        n_blank = $urandom_range(0, 1) ? $urandom_range(1, 3) : 0;
        n_digit = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40)
                                              : $urandom_range(0, 10);
        first   = 1'b1;
        repeat (n_blank) begin
            send_char(random_blank(), first);
            first = 1'b0;
        end
        repeat (n_digit) begin
            send_char(random_digit_char(radix), first);
            first = 1'b0;
        end
        do begin
            term = 8'($urandom_range(0, 255));
        end while (char_is_digit(term, radix) ||
                   (cfg_skip && n_digit == 0 && (term == CHAR_SPACE || term == CHAR_TAB)));
        send_char(term, first);
    endtask

    // Random scans under a series of settings, with some noise mixed in.
    task automatic test_random_traffic();
        logic [5:0] base;
        logic       skip;
        int         phase_end;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: base = 6'd2;
                1: base = 6'd36;
                2: base = 6'd0;
                3: base = 6'd63;
                4: base = 6'd16;
                5: base = 6'd10;
                6: base = 6'd1;
                7: base = 6'd37;
                default: base = 6'($urandom_range(0, 63));
            endcase
            skip = (p < 8) ? p[0] : 1'($urandom_range(0, 1));
            drain_block();
            write_config(base, skip);
            phase_end = chars_sent + RANDOM_ITEMS / RANDOM_PHASES;
            while (chars_sent < phase_end) begin
                if ($urandom_range(0, 99) < 85) begin
                    random_scan();
                end else begin
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                end
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_defaults();
        test_idle_and_empty();
        test_blanks_letters_restart();
        test_radix_clamp();
        test_output_backpressure();
        test_random_traffic();
        drain_block();

        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
